FILE: src/cll_pkg.sv
// Shared types and constants for the cursor linked list engine.
// Holds the command and status codes and the fixed field widths.
// It has no dependencies.
package cll_pkg;

  localparam int FUNC_W   = 4;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_QUERY      = 4'd0,
    FN_GO_START   = 4'd1,
    FN_GO_END     = 4'd2,
    FN_FORWARD    = 4'd3,
    FN_BACKWARD   = 4'd4,
    FN_INS_BEFORE = 4'd5,
    FN_INS_AFTER  = 4'd6,
    FN_SET_BEFORE = 4'd7,
    FN_SET_AFTER  = 4'd8,
    FN_DEL_BEFORE = 4'd9,
    FN_DEL_AFTER  = 4'd10
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_ZERO     = 2'd1,
    ST_BOUNDARY = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

endpackage

FILE: src/cursor_linked_list_engine_core.sv
// Top level of the cursor linked list engine: slot pool, links and command logic.
// Depends on cll_pkg for command codes, status codes and field widths.
//
// The engine holds a doubly linked list in a pool of SLOTS slots kept in
// flip-flops, with head, tail and cursor pointers. It accepts one command per
// clock cycle while in_stall is low; the result of a command appears on the
// output registers in the cycle after the command's transaction, so without
// out_stall the rate is one command per cycle. The critical path runs through the
// link reads at the cursor, the find-first free-slot encoder over the slot-used
// bitmap and the neighbor reads of the updated list. While a result is held
// by out_stall, in_stall is high. No clearing pass follows reset: the list is
// empty at once.
module cursor_linked_list_engine_core #(
  parameter int SLOTS      = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cll_pkg::FUNC_W-1:0]   func,
  input  logic [cll_pkg::DATA_W-1:0]   value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cll_pkg::DATA_W-1:0]   before_value,
  output logic [cll_pkg::DATA_W-1:0]   after_value,
  output logic [cll_pkg::DATA_W-1:0]   cursor_value,
  output logic                         at_head,
  output logic                         at_tail,
  output logic [cll_pkg::COUNT_W-1:0]  count,
  output logic [cll_pkg::STATUS_W-1:0] status
);
  import cll_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int KB = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;

  logic [KB-1:0]    slot_values [SLOTS];
  logic [IW-1:0]    prev_links  [SLOTS];
  logic [IW-1:0]    next_links  [SLOTS];
  logic [SLOTS-1:0] slot_used;
  logic [IW-1:0]    head_slot;
  logic [IW-1:0]    tail_slot;
  logic [IW-1:0]    cursor_slot;
  logic [CW-1:0]    list_count;

  logic [KB-1:0]    slot_values_next [SLOTS];
  logic [IW-1:0]    prev_links_next  [SLOTS];
  logic [IW-1:0]    next_links_next  [SLOTS];
  logic [SLOTS-1:0] slot_used_next;
  logic [IW-1:0]    head_slot_next;
  logic [IW-1:0]    tail_slot_next;
  logic [IW-1:0]    cursor_slot_next;
  logic [CW-1:0]    list_count_next;
  status_t          status_next;

  logic          accept;
  logic [KB-1:0] kept;
  logic          kept_zero;
  logic          empty;
  logic          cur_at_head;
  logic          cur_at_tail;
  logic [IW-1:0] pc;
  logic [IW-1:0] nc;
  logic [IW-1:0] free_slot;
  logic          pool_full;
  logic          new_empty;
  logic          new_at_head;
  logic          new_at_tail;
  logic [IW-1:0] new_pc;
  logic [IW-1:0] new_nc;

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign kept      = value[KB-1:0];
  assign kept_zero = (kept == '0);
  assign empty     = (list_count == '0);
  assign cur_at_head = empty || (cursor_slot == head_slot);
  assign cur_at_tail = empty || (cursor_slot == tail_slot);
  assign pc        = prev_links[cursor_slot];
  assign nc        = next_links[cursor_slot];
  assign pool_full = &slot_used;

  always_comb begin
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_slot = IW'(i);
      end
    end
  end

  always_comb begin
    slot_values_next = slot_values;
    prev_links_next  = prev_links;
    next_links_next  = next_links;
    slot_used_next   = slot_used;
    head_slot_next   = head_slot;
    tail_slot_next   = tail_slot;
    cursor_slot_next = cursor_slot;
    list_count_next  = list_count;
    status_next      = ST_DONE;
    case (func)
      FN_GO_START: begin
        if (!empty) begin
          cursor_slot_next = head_slot;
        end
      end
      FN_GO_END: begin
        if (!empty) begin
          cursor_slot_next = tail_slot;
        end
      end
      FN_FORWARD: begin
        if (cur_at_tail) begin
          status_next = ST_BOUNDARY;
        end else begin
          cursor_slot_next = nc;
        end
      end
      FN_BACKWARD: begin
        if (cur_at_head) begin
          status_next = ST_BOUNDARY;
        end else begin
          cursor_slot_next = pc;
        end
      end
      FN_INS_BEFORE, FN_INS_AFTER: begin
        if (kept_zero) begin
          status_next = ST_ZERO;
        end else if (pool_full) begin
          status_next = ST_FULL;
        end else begin
          slot_values_next[free_slot] = kept;
          slot_used_next[free_slot]   = 1'b1;
          list_count_next             = list_count + CW'(1);
          if (empty) begin
            head_slot_next             = free_slot;
            tail_slot_next             = free_slot;
            cursor_slot_next           = free_slot;
            prev_links_next[free_slot] = free_slot;
            next_links_next[free_slot] = free_slot;
          end else if (func == FN_INS_BEFORE) begin
            prev_links_next[free_slot] = pc;
            next_links_next[free_slot] = cursor_slot;
            if (cur_at_head) begin
              head_slot_next = free_slot;
            end else begin
              next_links_next[pc] = free_slot;
            end
            prev_links_next[cursor_slot] = free_slot;
          end else begin
            next_links_next[free_slot] = nc;
            prev_links_next[free_slot] = cursor_slot;
            if (cur_at_tail) begin
              tail_slot_next = free_slot;
            end else begin
              prev_links_next[nc] = free_slot;
            end
            next_links_next[cursor_slot] = free_slot;
          end
        end
      end
      FN_SET_BEFORE: begin
        if (kept_zero) begin
          status_next = ST_ZERO;
        end else if (cur_at_head) begin
          status_next = ST_BOUNDARY;
        end else begin
          slot_values_next[pc] = kept;
        end
      end
      FN_SET_AFTER: begin
        if (kept_zero) begin
          status_next = ST_ZERO;
        end else if (cur_at_tail) begin
          status_next = ST_BOUNDARY;
        end else begin
          slot_values_next[nc] = kept;
        end
      end
      FN_DEL_BEFORE: begin
        if (cur_at_head) begin
          status_next = ST_BOUNDARY;
        end else begin
          if (pc == head_slot) begin
            head_slot_next = cursor_slot;
          end else begin
            next_links_next[prev_links[pc]] = cursor_slot;
          end
          prev_links_next[cursor_slot] = prev_links[pc];
          slot_used_next[pc]           = 1'b0;
          slot_values_next[pc]         = '0;
          list_count_next              = list_count - CW'(1);
        end
      end
      FN_DEL_AFTER: begin
        if (cur_at_tail) begin
          status_next = ST_BOUNDARY;
        end else begin
          if (nc == tail_slot) begin
            tail_slot_next = cursor_slot;
          end else begin
            prev_links_next[next_links[nc]] = cursor_slot;
          end
          next_links_next[cursor_slot] = next_links[nc];
          slot_used_next[nc]           = 1'b0;
          slot_values_next[nc]         = '0;
          list_count_next              = list_count - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign new_empty   = (list_count_next == '0);
  assign new_at_head = new_empty || (cursor_slot_next == head_slot_next);
  assign new_at_tail = new_empty || (cursor_slot_next == tail_slot_next);
  assign new_pc      = prev_links_next[cursor_slot_next];
  assign new_nc      = next_links_next[cursor_slot_next];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used   <= '0;
      head_slot   <= '0;
      tail_slot   <= '0;
      cursor_slot <= '0;
      list_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        out_valid   <= 1'b1;
        slot_used   <= slot_used_next;
        head_slot   <= head_slot_next;
        tail_slot   <= tail_slot_next;
        cursor_slot <= cursor_slot_next;
        list_count  <= list_count_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_values  <= slot_values_next;
      prev_links   <= prev_links_next;
      next_links   <= next_links_next;
      before_value <= new_at_head ? '0 : DATA_W'($signed(slot_values_next[new_pc]));
      after_value  <= new_at_tail ? '0 : DATA_W'($signed(slot_values_next[new_nc]));
      cursor_value <= new_empty ? '0 :
                      DATA_W'($signed(slot_values_next[cursor_slot_next]));
      at_head      <= new_at_head;
      at_tail      <= new_at_tail;
      count        <= COUNT_W'(list_count_next);
      status       <= status_next;
    end
  end

  a_count_matches_used: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_used) == int'(list_count))
    else $error("List length disagrees with the slot-used bitmap.");

  a_cursor_slot_used: assert property (@(posedge clk) disable iff (rst)
    (list_count != '0) |-> slot_used[cursor_slot])
    else $error("Cursor points at a free slot.");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> pool_full)
    else $error("Pool-full status reported while a slot is free.");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && status_next == ST_DONE &&
     (func == FN_INS_BEFORE || func == FN_INS_AFTER))
    |=> list_count == $past(list_count) + CW'(1))
    else $error("Completed insert did not grow the list.");

endmodule
